// ===== rtl/core/kves_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kves_pkg
// shared types and constants for the key/value exchange sorter
// ----------------------------------------------------------------------------
package kves_pkg;

    localparam int DEPTH_DEF = 32;
    localparam int KEY_W     = 16;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 5;
    localparam int ENTRY_W   = KEY_W + VAL_W;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic             last;
    } req_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_I,
        ST_RD_J,
        ST_CMP,
        ST_WB,
        ST_OUT_RD,
        ST_OUT_WAIT
    } state_t;

endpackage

// ===== rtl/core/kves_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kves_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module kves_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/kves_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kves_front
// two entry request queue between the s_ input and the back end
// ----------------------------------------------------------------------------
module kves_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [kves_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                         s_tlast,
    output logic                         q_valid,
    input  logic                         q_ready,
    output kves_pkg::req_t               q_req
);

    kves_pkg::req_t mem_reg [2];
    logic           wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]     cnt_reg, cnt_next;
    logic           push, pop;

    assign s_tready = (cnt_reg != 2'd2);
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && q_ready;
    assign q_req    = mem_reg[rp_reg];

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wp_reg] <= '{key: s_tdata[kves_pkg::KEY_W-1:0],
                                 value: s_tdata[kves_pkg::ENTRY_W-1:kves_pkg::KEY_W],
                                 last: s_tlast};
        end
    end

endmodule

// ===== rtl/core/kves_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kves_back
// entry store, exchange sort sequencer and sorted read-out
// ----------------------------------------------------------------------------
module kves_back #(
    parameter int DEPTH = kves_pkg::DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           sort_order,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  kves_pkg::req_t                 q_req,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kves_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    kves_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next;
    logic          drop_reg, drop_next;
    logic [kves_pkg::ENTRY_W-1:0] ei_reg, ei_next;
    logic          ov_valid_reg, ov_valid_next;
    logic [kves_pkg::ENTRY_W-1:0] ov_data_reg, ov_data_next;
    logic [CW-1:0] ov_pos_reg, ov_pos_next;
    logic          ov_last_reg, ov_last_next, ov_drop_reg, ov_drop_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [kves_pkg::ENTRY_W-1:0] wdata, rdata;
    logic signed [kves_pkg::VAL_W-1:0] vi, vj;
    logic          swap;

    kves_ram #(.WIDTH(kves_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign vi   = ei_reg[kves_pkg::VAL_W-1:0];
    assign vj   = rdata[kves_pkg::VAL_W-1:0];
    assign swap = sort_order ? (vj > vi) : (vj < vi);

    assign m_tvalid = ov_valid_reg;
    assign m_tlast  = ov_last_reg;
    assign m_tuser  = ov_drop_reg;
    assign m_tdata  = {3'b000, ov_pos_reg[kves_pkg::POS_W-1:0],
                       ov_data_reg[kves_pkg::VAL_W-1:0],
                       ov_data_reg[kves_pkg::ENTRY_W-1:kves_pkg::VAL_W]};

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        drop_next     = drop_reg;
        ei_next       = ei_reg;
        ov_valid_next = ov_valid_reg && !m_tready;
        ov_data_next  = ov_data_reg;
        ov_pos_next   = ov_pos_reg;
        ov_last_next  = ov_last_reg;
        ov_drop_next  = ov_drop_reg;
        q_ready       = 1'b0;
        we            = 1'b0;
        waddr         = cnt_reg[AW-1:0];
        wdata         = {q_req.key, q_req.value};
        raddr         = i_reg[AW-1:0];
        case (state_reg)
            kves_pkg::ST_LOAD: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    if (cnt_reg < CW'(DEPTH)) begin
                        we       = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        drop_next = 1'b1;
                    end
                    if (q_req.last) begin
                        i_next     = '0;
                        state_next = kves_pkg::ST_RD_I;
                    end
                end
            end
            kves_pkg::ST_RD_I: begin
                raddr = i_reg[AW-1:0];
                j_next = i_reg + 1'b1;
                if (i_reg + 1'b1 >= cnt_reg) begin
                    i_next     = '0;
                    state_next = kves_pkg::ST_OUT_RD;
                end else begin
                    state_next = kves_pkg::ST_RD_J;
                end
            end
            kves_pkg::ST_RD_J: begin
                ei_next    = rdata;
                raddr      = j_reg[AW-1:0];
                state_next = kves_pkg::ST_CMP;
            end
            kves_pkg::ST_CMP: begin
                if (swap) begin
                    we      = 1'b1;
                    waddr   = j_reg[AW-1:0];
                    wdata   = ei_reg;
                    ei_next = rdata;
                end
                if (j_reg + 1'b1 >= cnt_reg) begin
                    state_next = kves_pkg::ST_WB;
                end else begin
                    j_next     = j_reg + 1'b1;
                    state_next = kves_pkg::ST_CMP;
                end
                raddr = j_next[AW-1:0];
            end
            kves_pkg::ST_WB: begin
                we         = 1'b1;
                waddr      = i_reg[AW-1:0];
                wdata      = ei_reg;
                i_next     = i_reg + 1'b1;
                state_next = kves_pkg::ST_RD_I;
            end
            kves_pkg::ST_OUT_RD: begin
                raddr      = i_reg[AW-1:0];
                state_next = kves_pkg::ST_OUT_WAIT;
            end
            kves_pkg::ST_OUT_WAIT: begin
                raddr = i_reg[AW-1:0];
                if (!ov_valid_reg || m_tready) begin
                    ov_valid_next = 1'b1;
                    ov_data_next  = rdata;
                    ov_pos_next   = i_reg;
                    ov_last_next  = (i_reg + 1'b1 == cnt_reg);
                    ov_drop_next  = drop_reg;
                    if (i_reg + 1'b1 == cnt_reg) begin
                        cnt_next   = '0;
                        drop_next  = 1'b0;
                        state_next = kves_pkg::ST_LOAD;
                    end else begin
                        i_next     = i_reg + 1'b1;
                        state_next = kves_pkg::ST_OUT_RD;
                    end
                end
            end
            default: state_next = kves_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= kves_pkg::ST_LOAD;
            cnt_reg      <= '0;
            drop_reg     <= 1'b0;
            ov_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            drop_reg     <= drop_next;
            ov_valid_reg <= ov_valid_next;
        end
        i_reg       <= i_next;
        j_reg       <= j_next;
        ei_reg      <= ei_next;
        ov_data_reg <= ov_data_next;
        ov_pos_reg  <= ov_pos_next;
        ov_last_reg <= ov_last_next;
        ov_drop_reg <= ov_drop_next;
    end

endmodule

// ===== rtl/core/key_value_exchange_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_exchange_sorter
// collects key/value pairs, exchange sorts them by value, streams them out
//
// channel  dir  data                                   side
// s_       in   tdata: entry_key, entry_value          tlast: batch_end
// m_       out  tdata: out_key, out_value, position    tlast: final_entry,
//                                                      tuser: overflowed
// cfg      in   cfg_wdata: sort_order
//
// pairs load one per cycle through a two-entry request queue while the sorter is loading
// on batch end the pairs stored in the ram are exchange sorted, followed by
// an out_rd and an out_wait state per result read-out
// reset is synchronous; the store comes up empty with no clearing pass
// a stalled m_ side holds the read-out; the s_ side fills the queue then stalls
// ----------------------------------------------------------------------------
module key_value_exchange_sorter #(
    parameter int DEPTH = kves_pkg::DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,      // sort_order
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [kves_pkg::S_TDATA_W-1:0] s_tdata,        // entry_key, entry_value
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [kves_pkg::M_TDATA_W-1:0] m_tdata,        // out_key, out_value, position
    output logic                           m_tlast,
    output logic                           m_tuser         // overflowed
);

    logic           order_reg;
    logic           q_valid, q_ready;
    kves_pkg::req_t q_req;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg <= 1'b0;
        end else if (cfg_we) begin
            order_reg <= cfg_wdata;
        end
    end

    kves_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
    );

    kves_back #(.DEPTH(DEPTH)) u_back (
        .aclk(aclk), .aresetn(aresetn), .sort_order(order_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

endmodule

// ===== test/tb_key_value_exchange_sorter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_exchange_sorter
// self-checking bench for the key/value exchange sorter: batches of requests
// are streamed in with random bursts and gaps, results are collected under
// random back-pressure and compared against a behavioral exchange sort
// ----------------------------------------------------------------------------
module tb_key_value_exchange_sorter;

    localparam int DEPTH = kves_pkg::DEPTH_DEF;

    typedef struct {
        logic [kves_pkg::KEY_W-1:0] key;
        logic [kves_pkg::VAL_W-1:0] value;
        logic                       last;
    } pair_t;

    typedef struct {
        logic [kves_pkg::KEY_W-1:0] key;
        logic [kves_pkg::VAL_W-1:0] value;
        logic [kves_pkg::POS_W-1:0] pos;
        logic                       fin;
        logic                       ovf;
    } sorted_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [kves_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [kves_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic m_tuser;

    pair_t   pending_q[$];
    sorted_t sorted_q[$];
    logic [kves_pkg::KEY_W-1:0] key_mem[DEPTH];
    logic [kves_pkg::VAL_W-1:0] val_mem[DEPTH];
    int    fill_cnt = 0;
    logic  dropped = 1'b0;
    logic  descending = 1'b0;
    int    errors = 0;
    int    batches = 0;
    int    results_seen = 0;
    int    burst_left = 0;
    int    gap_left = 0;
    int    hold_cycles = 0;
    logic  hold_req = 1'b0;
    logic  sender_pause = 1'b0;
    logic  busy;

    key_value_exchange_sorter #(.DEPTH(DEPTH)) dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor: store, sort on batch end, queue the sorted run
    function automatic void predict_pair(pair_t p);
        logic [kves_pkg::KEY_W-1:0] tk;
        logic [kves_pkg::VAL_W-1:0] tv;
        logic swap;
        sorted_t r;
        if (fill_cnt < DEPTH) begin
            key_mem[fill_cnt] = p.key;
            val_mem[fill_cnt] = p.value;
            fill_cnt++;
        end else begin
            dropped = 1'b1;
        end
        if (!p.last) return;
        for (int i = 0; i < fill_cnt; i++) begin
            for (int j = i + 1; j < fill_cnt; j++) begin
                swap = descending ? ($signed(val_mem[j]) > $signed(val_mem[i]))
                                  : ($signed(val_mem[j]) < $signed(val_mem[i]));
                if (swap) begin
                    tk = key_mem[i]; tv = val_mem[i];
                    key_mem[i] = key_mem[j]; val_mem[i] = val_mem[j];
                    key_mem[j] = tk; val_mem[j] = tv;
                end
            end
        end
        for (int k = 0; k < fill_cnt; k++) begin
            r.key = key_mem[k];
            r.value = val_mem[k];
            r.pos = k[kves_pkg::POS_W-1:0];
            r.fin = (k + 1 == fill_cnt);
            r.ovf = dropped;
            sorted_q.push_back(r);
        end
        fill_cnt = 0;
        dropped = 1'b0;
        batches++;
    endfunction

    // driver
    always @(posedge aclk) begin
        pair_t p;
        if (s_tvalid && s_tready) begin
            predict_pair(pending_q.pop_front());
        end
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!(s_tvalid && !s_tready)) begin
            if (!sender_pause && gap_left == 0 && pending_q.size() > 0) begin
                p = pending_q[0];
                s_tvalid <= 1'b1;
                s_tdata <= {p.value, p.key};
                s_tlast <= p.last;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                end else if (burst_left == 1) begin
                    burst_left <= 0;
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_tvalid <= 1'b0;
                if (gap_left > 0) gap_left <= gap_left - 1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        sorted_t e;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (sorted_q.size() == 0) begin
                $error("unexpected result %h", m_tdata);
                errors++;
            end else begin
                e = sorted_q.pop_front();
                if (m_tdata[kves_pkg::KEY_W-1:0] !== e.key) begin
                    $error("out_key exp %h got %h", e.key, m_tdata[kves_pkg::KEY_W-1:0]);
                    errors++;
                end
                if (m_tdata[kves_pkg::ENTRY_W-1:kves_pkg::KEY_W] !== e.value) begin
                    $error("out_value exp %h got %h", e.value,
                           m_tdata[kves_pkg::ENTRY_W-1:kves_pkg::KEY_W]);
                    errors++;
                end
                if (m_tdata[kves_pkg::ENTRY_W+kves_pkg::POS_W-1:kves_pkg::ENTRY_W]
                    !== e.pos) begin
                    $error("position exp %0d got %0d", e.pos,
                           m_tdata[kves_pkg::ENTRY_W+kves_pkg::POS_W-1:kves_pkg::ENTRY_W]);
                    errors++;
                end
                if (m_tlast !== e.fin) begin
                    $error("final_entry exp %b got %b", e.fin, m_tlast);
                    errors++;
                end
                if (m_tuser !== e.ovf) begin
                    $error("overflowed exp %b got %b", e.ovf, m_tuser);
                    errors++;
                end
            end
        end
    end

    // receiver stall pattern with an optional long hold-off
    always @(posedge aclk) begin
        if (hold_req && hold_cycles == 0) begin
            hold_cycles <= 1500;
            m_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= (hold_cycles == 1);
        end else begin
            m_tready <= ($urandom_range(0, 7) < 5) || results_seen[6];
        end
    end

    assign busy = (pending_q.size() > 0) || (sorted_q.size() > 0) || s_tvalid;

    function automatic pair_t rand_pair(logic last);
        pair_t p;
        p.key = 16'($urandom());
        case ($urandom_range(0, 5))
            0: p.value = 32'h8000_0000;
            1: p.value = 32'h7fff_ffff;
            2: p.value = $urandom_range(0, 7) << 16;
            default: p.value = $urandom();
        endcase
        p.last = last;
        return p;
    endfunction

    task automatic add_batch(int n);
        for (int i = 0; i < n; i++) pending_q.push_back(rand_pair(i == n - 1));
    endtask

    task automatic drain();
        wait (!busy);
        repeat (2 * DEPTH * DEPTH + 200) @(posedge aclk);
    endtask

    task automatic write_order(logic v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        descending = v;
    endtask

    initial begin
        pair_t p;
        int sent;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: single entry, extremes, ties, ascending
        p = '{16'h8000, 32'h7fff_ffff, 1'b1};
        pending_q.push_back(p);
        pending_q.push_back('{16'h7fff, 32'h8000_0000, 1'b0});
        pending_q.push_back('{16'h0001, 32'h0001_0000, 1'b0});
        pending_q.push_back('{16'h0002, 32'h0001_0000, 1'b0});
        pending_q.push_back('{16'hffff, 32'hffff_ffff, 1'b0});
        pending_q.push_back('{16'h0000, 32'h0000_0000, 1'b1});
        drain();
        write_order(1'b1);
        pending_q.push_back('{16'h1234, 32'h0001_0000, 1'b0});
        pending_q.push_back('{16'h4321, 32'h0001_0000, 1'b0});
        pending_q.push_back('{16'hffff, 32'h8000_0000, 1'b0});
        pending_q.push_back('{16'h5555, 32'h7fff_ffff, 1'b1});
        drain();
        // overflow: depth + 3 items, last one dropped too
        add_batch(DEPTH + 3);
        drain();
        write_order(1'b0);
        // long receiver hold-off while the sender keeps offering
        hold_req = 1'b1;
        add_batch(DEPTH);
        add_batch(5);
        wait (hold_cycles > 0);
        hold_req = 1'b0;
        drain();
        // random part
        sent = 0;
        while (sent < 330) begin
            int n;
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 4)
                                            : $urandom_range(1, 10);
            add_batch(n);
            sent += n;
            if ($urandom_range(0, 5) == 0) begin
                drain();
                write_order(1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 7) == 0) begin
                sender_pause = 1'b1;
                wait (sorted_q.size() == 0);
                sender_pause = 1'b0;
            end
        end
        drain();
        $display("ran %0d batches with %0d results, both sort orders, overflow and stalls",
                 batches, results_seen);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

endmodule
